// ----- hw/rtl/affine_sum_squares_mod_assert.svh -----
`ifndef AFFINE_SUM_SQUARES_MOD_ASSERT_SVH
`define AFFINE_SUM_SQUARES_MOD_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ASSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assm check failed");

// next-cycle implication, checked out of reset
`define ASSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assm check failed");

`endif

// ----- hw/rtl/assm_pkg.sv -----
package assm_pkg;

    localparam int unsigned MOD_W = 31;
    localparam int unsigned RED_LAT = 5;

    typedef logic [MOD_W-1:0] res_t;

    typedef enum logic [1:0]
    {
        FUNC_APPLY   = 2'd0,
        FUNC_COMPOSE = 2'd1,
        FUNC_MERGE   = 2'd2
    } func_t;

    localparam res_t        RESET_MODULUS = 31'd998244353;
    localparam logic [63:0] RESET_MU      = 64'((65'd1 << 64) / 65'd998244353);

    // (x + y) mod m for x, y already below m
    function automatic res_t add_mod(res_t x, res_t y, res_t m);
        logic [MOD_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[MOD_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/assm_red.sv -----
// Barrett reduction of a 64-bit value, mu = floor(2^64 / modulus), five stages.
module assm_red
(
    input  logic                clk,
    input  logic                ce,
    input  logic [63:0]         x,
    input  logic [63:0]         mu,
    input  assm_pkg::res_t      modulus,
    output assm_pkg::res_t      r
);

    logic [63:0]  x1_reg;
    logic [63:0]  p_hh_reg;
    logic [63:0]  p_hl_reg;
    logic [63:0]  p_lh_reg;
    logic [63:0]  p_ll_reg;
    logic [33:0]  x2_reg;
    logic [63:0]  q_reg;
    logic [127:0] acc_next;
    logic [33:0]  x3_reg;
    logic [62:0]  qm_h_reg;
    logic [62:0]  qm_l_reg;
    logic [33:0]  rem_reg;
    logic [33:0]  rem_next;
    assm_pkg::res_t r_reg;
    assm_pkg::res_t r_next;
    logic [33:0]  m1;
    logic [33:0]  m2;

    always_comb
    begin
        acc_next = {p_hh_reg, 64'd0}
                 + {32'd0, p_hl_reg, 32'd0}
                 + {32'd0, p_lh_reg, 32'd0}
                 + {64'd0, p_ll_reg};
        rem_next = x3_reg - qm_l_reg[33:0] - {qm_h_reg[1:0], 32'd0};
        m1 = {3'd0, modulus};
        m2 = {2'd0, modulus, 1'b0};
        // quotient estimate is short by at most two
        if (rem_reg >= m2)
        begin
            r_next = assm_pkg::res_t'(rem_reg - m2);
        end
        else if (rem_reg >= m1)
        begin
            r_next = assm_pkg::res_t'(rem_reg - m1);
        end
        else
        begin
            r_next = rem_reg[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x1_reg   <= x;
            p_hh_reg <= x[63:32] * mu[63:32];
            p_hl_reg <= x[63:32] * mu[31:0];
            p_lh_reg <= x[31:0] * mu[63:32];
            p_ll_reg <= x[31:0] * mu[31:0];
            x2_reg   <= x1_reg[33:0];
            q_reg    <= acc_next[127:64];
            x3_reg   <= x2_reg;
            qm_h_reg <= q_reg[63:32] * modulus;
            qm_l_reg <= q_reg[31:0] * modulus;
            rem_reg  <= rem_next;
            r_reg    <= r_next;
        end
    end

    assign r = r_reg;

endmodule

// ----- hw/rtl/affine_sum_squares_mod.sv -----
// Affine lazy-tag kernel: apply tag to (len, sum, sq), compose tags, merge summaries,
// all modulo a programmable modulus.
// Input stream s_*: one word per operation, tuser carries the operation code.
// Output stream m_*: exactly one word per accepted input word, in order.
// Config: cfg_we with cfg_wdata loads the modulus; values below 2 are dropped.
//   A load starts the reciprocal calculation; s_tready stays low meanwhile.
//   Load only while the pipeline is empty.
// Pipeline from input accept to m_tvalid: three levels of Barrett reducers of
// five stages each, plus input, fix-up, multiply and output stages.
// Throughput: one word per cycle, except during a stall or a reciprocal calculation.
// Reset: pipeline empty, modulus 998244353 with its reciprocal ready, so words
// are taken right after reset.
// Stall: when m_tvalid is high and m_tready low the whole pipeline holds; no word
// is dropped or repeated, and s_tready drops until the output word leaves.
module affine_sum_squares_mod
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // len, sum, sq, other_len, other_sum, other_sq, mul, add, old_mul, old_add, pad
    input  logic [383:0] s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_len, out_sum, out_sq, out_mul, out_add, pad
    output logic [159:0] m_tdata,
    input  logic         cfg_we,
    input  logic [30:0]  cfg_wdata
);

    localparam int unsigned RL = assm_pkg::RED_LAT;
    localparam int unsigned PIPE_DEPTH = 3 * RL + 6;
    localparam logic [6:0]  DIV_STEPS = 7'd65;

    typedef assm_pkg::res_t res_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] len;
        logic [31:0] mlen;
        logic        negm;
        logic        nega;
    } side1_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] len;
        logic [31:0] mlen;
        res_t        m;
        res_t        a;
        res_t        sum;
        res_t        lm;
        res_t        ssum;
        res_t        ssq;
    } side2_t;

    typedef struct packed {
        side2_t      s;
        res_t        sq;
        res_t        omul;
        res_t        oadd;
    } c1_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] len;
        logic [31:0] mlen;
        res_t        m;
        res_t        a;
        res_t        ssum;
        res_t        ssq;
        res_t        summ;
        res_t        alm;
        res_t        cmul;
        res_t        cadd;
    } side3_t;

    typedef struct packed {
        side3_t      s;
        res_t        sqm;
        res_t        ma2;
        res_t        aa;
        res_t        sum;
        res_t        lm;
    } c2_t;

    // reducer lane indices
    localparam int unsigned L1_LEN = 0, L1_SUM = 1, L1_SQ = 2, L1_OSUM = 3, L1_OSQ = 4;
    localparam int unsigned L1_MUL = 5, L1_ADD = 6, L1_OMUL = 7, L1_OADD = 8;
    localparam int unsigned L2_SQM = 0, L2_MA = 1, L2_AA = 2, L2_SUMM = 3, L2_ALM = 4;
    localparam int unsigned L2_OMULM = 5, L2_OADDM = 6;

    // modulus and reciprocal
    res_t        mod_reg;
    logic [63:0] mu_reg;
    logic [30:0] div_rem_reg;
    logic [6:0]  div_cnt_reg;
    logic [31:0] div_try;
    logic        busy;

    logic                  ce;
    logic [PIPE_DEPTH-1:0] vld_reg;

    // input stage
    side1_t      s0_side_reg;
    logic [63:0] s0_x_reg [9];
    side1_t      s0_side_next;
    logic [63:0] mul_raw;
    logic [63:0] add_raw;
    logic [32:0] len_sum;

    side1_t      side1_dly_reg [RL];
    res_t        r1 [9];
    c1_t         c1_reg;
    c1_t         c1_next;

    logic [63:0] p2_x_reg [7];
    side2_t      p2_side_reg;
    side2_t      side2_dly_reg [RL];
    res_t        r2 [7];
    c2_t         c2_reg;
    c2_t         c2_next;
    logic [62:0] ma_dbl;

    logic [63:0] p3_x_reg [3];
    side3_t      p3_side_reg;
    side3_t      side3_dly_reg [RL];
    res_t        r3 [3];

    logic [31:0] out_len_reg;
    res_t        out_sum_reg;
    res_t        out_sq_reg;
    res_t        out_mul_reg;
    res_t        out_add_reg;
    logic [31:0] out_len_next;
    res_t        out_sum_next;
    res_t        out_sq_next;
    res_t        out_mul_next;
    res_t        out_add_next;
    side3_t      s3;

    assign busy     = (div_cnt_reg != 7'd0);
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce && !busy;

    // reciprocal: restoring division of 2^64 by the modulus, one bit per cycle
    assign div_try = {div_rem_reg, (div_cnt_reg == DIV_STEPS)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg     <= assm_pkg::RESET_MODULUS;
            mu_reg      <= assm_pkg::RESET_MU;
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
        end
        else if (cfg_we && (cfg_wdata >= 31'd2))
        begin
            mod_reg     <= cfg_wdata;
            mu_reg      <= '0;
            div_rem_reg <= '0;
            div_cnt_reg <= DIV_STEPS;
        end
        else if (busy)
        begin
            div_cnt_reg <= div_cnt_reg - 7'd1;
            if (div_try >= {1'b0, mod_reg})
            begin
                div_rem_reg <= 31'(div_try - {1'b0, mod_reg});
                mu_reg      <= {mu_reg[62:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_try[30:0];
                mu_reg      <= {mu_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid && s_tready};
        end
    end

    // ---------------- input stage ----------------
    assign mul_raw = s_tdata[251:188];
    assign add_raw = s_tdata[315:252];
    assign len_sum = {1'b0, s_tdata[31:0]} + {1'b0, s_tdata[125:94]};

    always_comb
    begin
        s0_side_next.func = s_tuser;
        s0_side_next.len  = s_tdata[31:0];
        s0_side_next.mlen = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
        s0_side_next.negm = mul_raw[63];
        s0_side_next.nega = add_raw[63];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s0_side_reg        <= s0_side_next;
            s0_x_reg[L1_LEN]   <= {32'd0, s_tdata[31:0]};
            s0_x_reg[L1_SUM]   <= {33'd0, s_tdata[62:32]};
            s0_x_reg[L1_SQ]    <= {33'd0, s_tdata[93:63]};
            s0_x_reg[L1_OSUM]  <= {33'd0, s_tdata[156:126]};
            s0_x_reg[L1_OSQ]   <= {33'd0, s_tdata[187:157]};
            s0_x_reg[L1_MUL]   <= mul_raw[63] ? 64'(64'd0 - mul_raw) : mul_raw;
            s0_x_reg[L1_ADD]   <= add_raw[63] ? 64'(64'd0 - add_raw) : add_raw;
            s0_x_reg[L1_OMUL]  <= {33'd0, s_tdata[346:316]};
            s0_x_reg[L1_OADD]  <= {33'd0, s_tdata[377:347]};
        end
    end

    // ---------------- reduction level 1 ----------------
    for (genvar i = 0; i < 9; i++)
    begin : g_red1
        assm_red u_red
        (
            .clk     (clk),
            .ce      (ce),
            .x       (s0_x_reg[i]),
            .mu      (mu_reg),
            .modulus (mod_reg),
            .r       (r1[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side1_dly_reg[0] <= s0_side_reg;
            for (int i = 1; i < RL; i++)
            begin
                side1_dly_reg[i] <= side1_dly_reg[i-1];
            end
        end
    end

    // sign fix-up and merge sums
    always_comb
    begin
        c1_next.s.func = side1_dly_reg[RL-1].func;
        c1_next.s.len  = side1_dly_reg[RL-1].len;
        c1_next.s.mlen = side1_dly_reg[RL-1].mlen;
        if (side1_dly_reg[RL-1].negm && (r1[L1_MUL] != '0))
        begin
            c1_next.s.m = mod_reg - r1[L1_MUL];
        end
        else
        begin
            c1_next.s.m = r1[L1_MUL];
        end
        if (side1_dly_reg[RL-1].nega && (r1[L1_ADD] != '0))
        begin
            c1_next.s.a = mod_reg - r1[L1_ADD];
        end
        else
        begin
            c1_next.s.a = r1[L1_ADD];
        end
        c1_next.s.sum  = r1[L1_SUM];
        c1_next.s.lm   = r1[L1_LEN];
        c1_next.s.ssum = assm_pkg::add_mod(r1[L1_SUM], r1[L1_OSUM], mod_reg);
        c1_next.s.ssq  = assm_pkg::add_mod(r1[L1_SQ], r1[L1_OSQ], mod_reg);
        c1_next.sq     = r1[L1_SQ];
        c1_next.omul   = r1[L1_OMUL];
        c1_next.oadd   = r1[L1_OADD];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c1_reg <= c1_next;
        end
    end

    // ---------------- products level 2 ----------------
    // operands widened so each product keeps all 62 bits
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p2_side_reg         <= c1_reg.s;
            p2_x_reg[L2_SQM]    <= {2'd0, {31'd0, c1_reg.sq} * {31'd0, c1_reg.s.m}};
            p2_x_reg[L2_MA]     <= {2'd0, {31'd0, c1_reg.s.m} * {31'd0, c1_reg.s.a}};
            p2_x_reg[L2_AA]     <= {2'd0, {31'd0, c1_reg.s.a} * {31'd0, c1_reg.s.a}};
            p2_x_reg[L2_SUMM]   <= {2'd0, {31'd0, c1_reg.s.sum} * {31'd0, c1_reg.s.m}};
            p2_x_reg[L2_ALM]    <= {2'd0, {31'd0, c1_reg.s.a} * {31'd0, c1_reg.s.lm}};
            p2_x_reg[L2_OMULM]  <= {2'd0, {31'd0, c1_reg.omul} * {31'd0, c1_reg.s.m}};
            p2_x_reg[L2_OADDM]  <= {2'd0, {31'd0, c1_reg.oadd} * {31'd0, c1_reg.s.m}};
        end
    end

    for (genvar i = 0; i < 7; i++)
    begin : g_red2
        assm_red u_red
        (
            .clk     (clk),
            .ce      (ce),
            .x       (p2_x_reg[i]),
            .mu      (mu_reg),
            .modulus (mod_reg),
            .r       (r2[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side2_dly_reg[0] <= p2_side_reg;
            for (int i = 1; i < RL; i++)
            begin
                side2_dly_reg[i] <= side2_dly_reg[i-1];
            end
        end
    end

    always_comb
    begin
        ma_dbl           = {31'd0, r2[L2_MA], 1'b0};
        c2_next.s.func   = side2_dly_reg[RL-1].func;
        c2_next.s.len    = side2_dly_reg[RL-1].len;
        c2_next.s.mlen   = side2_dly_reg[RL-1].mlen;
        c2_next.s.m      = side2_dly_reg[RL-1].m;
        c2_next.s.a      = side2_dly_reg[RL-1].a;
        c2_next.s.ssum   = side2_dly_reg[RL-1].ssum;
        c2_next.s.ssq    = side2_dly_reg[RL-1].ssq;
        c2_next.s.summ   = r2[L2_SUMM];
        c2_next.s.alm    = r2[L2_ALM];
        c2_next.s.cmul   = r2[L2_OMULM];
        c2_next.s.cadd   = assm_pkg::add_mod(r2[L2_OADDM], side2_dly_reg[RL-1].a, mod_reg);
        c2_next.sqm      = r2[L2_SQM];
        // 2*m*a mod; also right for modulus 2
        if (ma_dbl >= {32'd0, mod_reg})
        begin
            c2_next.ma2 = res_t'(ma_dbl - {32'd0, mod_reg});
        end
        else
        begin
            c2_next.ma2 = ma_dbl[30:0];
        end
        c2_next.aa       = r2[L2_AA];
        c2_next.sum      = side2_dly_reg[RL-1].sum;
        c2_next.lm       = side2_dly_reg[RL-1].lm;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c2_reg <= c2_next;
        end
    end

    // ---------------- products level 3 ----------------
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p3_side_reg <= c2_reg.s;
            p3_x_reg[0] <= {2'd0, {31'd0, c2_reg.sqm} * {31'd0, c2_reg.s.m}};
            p3_x_reg[1] <= {2'd0, {31'd0, c2_reg.ma2} * {31'd0, c2_reg.sum}};
            p3_x_reg[2] <= {2'd0, {31'd0, c2_reg.aa} * {31'd0, c2_reg.lm}};
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_red3
        assm_red u_red
        (
            .clk     (clk),
            .ce      (ce),
            .x       (p3_x_reg[i]),
            .mu      (mu_reg),
            .modulus (mod_reg),
            .r       (r3[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side3_dly_reg[0] <= p3_side_reg;
            for (int i = 1; i < RL; i++)
            begin
                side3_dly_reg[i] <= side3_dly_reg[i-1];
            end
        end
    end

    // ---------------- output stage ----------------
    assign s3 = side3_dly_reg[RL-1];

    always_comb
    begin
        out_len_next = '0;
        out_sum_next = '0;
        out_sq_next  = '0;
        out_mul_next = '0;
        out_add_next = '0;
        case (s3.func)
            assm_pkg::FUNC_APPLY:
            begin
                out_len_next = s3.len;
                out_sum_next = assm_pkg::add_mod(s3.summ, s3.alm, mod_reg);
                out_sq_next  = assm_pkg::add_mod(assm_pkg::add_mod(r3[0], r3[1], mod_reg),
                                                 r3[2], mod_reg);
                out_mul_next = s3.m;
                out_add_next = s3.a;
            end
            assm_pkg::FUNC_COMPOSE:
            begin
                out_mul_next = s3.cmul;
                out_add_next = s3.cadd;
            end
            assm_pkg::FUNC_MERGE:
            begin
                out_len_next = s3.mlen;
                out_sum_next = s3.ssum;
                out_sq_next  = s3.ssq;
                out_mul_next = 31'd1;
            end
            default:
            begin
                out_len_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_len_reg <= out_len_next;
            out_sum_reg <= out_sum_next;
            out_sq_reg  <= out_sq_next;
            out_mul_reg <= out_mul_next;
            out_add_reg <= out_add_next;
        end
    end

    assign m_tdata = {4'd0, out_add_reg, out_mul_reg, out_sq_reg, out_sum_reg, out_len_reg};

    // ---------------- checks ----------------
`include "affine_sum_squares_mod_assert.svh"

    `ASSM_ASSERT_NOW(a_no_accept_busy, s_tvalid && s_tready, div_cnt_reg == 7'd0)
    `ASSM_ASSERT_NEXT(a_div_counts, busy && !cfg_we, div_cnt_reg == $past(div_cnt_reg) - 7'd1)
    `ASSM_ASSERT_NEXT(a_stall_freezes, m_tvalid && !m_tready, $stable(vld_reg))

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

class sumsq_scoreboard;
    logic [159:0] expected_q[$];
    int unsigned  errors;

    function void note_word(logic [159:0] e);
        expected_q.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_word(logic [159:0] got);
        logic [159:0] e;
        if (expected_q.size() == 0)
        begin
            $display("unexpected output word %h", got);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (got[31:0] !== e[31:0])
        begin
            report("out_len", got[31:0], e[31:0]);
        end
        if (got[62:32] !== e[62:32])
        begin
            report("out_sum", got[62:32], e[62:32]);
        end
        if (got[93:63] !== e[93:63])
        begin
            report("out_sq", got[93:63], e[93:63]);
        end
        if (got[124:94] !== e[124:94])
        begin
            report("out_mul", got[124:94], e[124:94]);
        end
        if (got[155:125] !== e[155:125])
        begin
            report("out_add", got[155:125], e[155:125]);
        end
        if (got[159:156] !== 4'd0)
        begin
            report("pad", got[159:156], 0);
        end
    endtask
endclass

module tb_top;

    localparam int unsigned PIPE_LAT = 21;
    localparam longint unsigned CYCLE_LIMIT = 400000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [383:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [30:0]  cfg_wdata = '0;

    sumsq_scoreboard sb = new();
    longint unsigned modulus = 998244353;
    longint unsigned cycles = 0;
    bit              hold_long = 1'b0;
    bit              done_sending = 1'b0;

    affine_sum_squares_mod u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned mulm(longint unsigned a, longint unsigned b);
        return (a * b) % modulus;
    endfunction

    // two's complement raw value folded into 0..modulus-1
    function automatic longint unsigned fold_signed(logic [63:0] raw);
        longint unsigned r;
        if (!raw[63])
        begin
            return raw % modulus;
        end
        r = (64'd0 - raw) % modulus;
        return (r != 0) ? modulus - r : 0;
    endfunction

    function automatic logic [159:0] predict_word(logic [1:0] fn, logic [383:0] d);
        longint unsigned len, sm, sq, olen, osm, osq, m, a, om, oa, lm, tot;
        longint unsigned r_len, r_sum, r_sq, r_mul, r_add;
        len  = d[31:0];
        sm   = d[62:32] % modulus;
        sq   = d[93:63] % modulus;
        olen = d[125:94];
        osm  = d[156:126] % modulus;
        osq  = d[187:157] % modulus;
        m    = fold_signed(d[251:188]);
        a    = fold_signed(d[315:252]);
        om   = d[346:316] % modulus;
        oa   = d[377:347] % modulus;
        r_len = 0; r_sum = 0; r_sq = 0; r_mul = 0; r_add = 0;
        case (fn)
            assm_pkg::FUNC_APPLY:
            begin
                lm = len % modulus;
                r_len = len;
                r_sq = (mulm(mulm(sq, m), m) + mulm(mulm(mulm(2 % modulus, m), a), sm)
                        + mulm(mulm(a, a), lm)) % modulus;
                r_sum = (mulm(sm, m) + mulm(a, lm)) % modulus;
                r_mul = m;
                r_add = a;
            end
            assm_pkg::FUNC_COMPOSE:
            begin
                r_mul = mulm(om, m);
                r_add = (mulm(oa, m) + a) % modulus;
            end
            assm_pkg::FUNC_MERGE:
            begin
                tot = len + olen;
                r_len = (tot > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : tot;
                r_sum = (sm + osm) % modulus;
                r_sq = (sq + osq) % modulus;
                r_mul = 1;
                r_add = 0;
            end
            default: ;
        endcase
        return {4'd0, r_add[30:0], r_mul[30:0], r_sq[30:0], r_sum[30:0], r_len[31:0]};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [30:0] rand_res();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'(modulus - 1);
            3: return 31'(modulus);
            default: return 31'($urandom());
        endcase
    endfunction

    function automatic logic [63:0] rand_tag();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'h7FFF_FFFF_FFFF_FFFF;
            3: return 64'hFFFF_FFFF_FFFF_FFFF;
            4: return 64'($signed($urandom_range(0, 20)) - 10);
            5: return 64'(modulus);
            default: return rand64();
        endcase
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(1, 16));
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge; leaves tvalid high so words can follow back to back
    task automatic send_word(logic [1:0] fn, logic [383:0] d);
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_word(predict_word(fn, d));
        @(negedge clk);
    endtask

    task automatic send_fields(logic [1:0] fn, logic [31:0] len, logic [30:0] sm,
                               logic [30:0] sq, logic [31:0] olen, logic [30:0] osm,
                               logic [30:0] osq, logic [63:0] m, logic [63:0] a,
                               logic [30:0] om, logic [30:0] oa);
        send_word(fn, {6'd0, oa, om, a, m, osq, osm, olen, sq, sm, len});
    endtask

    task automatic send_random(int count);
        repeat (count)
        begin
            send_fields(2'($urandom_range(0, 3)), rand_len(), rand_res(), rand_res(),
                        rand_len(), rand_res(), rand_res(), rand_tag(), rand_tag(),
                        rand_res(), rand_res());
        end
    endtask

    task automatic drain_and_load(logic [30:0] value);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (PIPE_LAT + 4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (value >= 2)
        begin
            modulus = value;
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_word(m_tdata);
        end
    end

    // output side back-pressure
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                m_tready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_long = 1'b0;
            end
            else if (done_sending || $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge clk);
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // apply: leaf build, assignment, extreme tags
        send_fields(assm_pkg::FUNC_APPLY, 32'd1, 31'd0, 31'd0, 0, 0, 0, 64'd0, 64'd12345,
                    0, 0);
        send_fields(assm_pkg::FUNC_APPLY, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                    0, 0, 0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_fields(assm_pkg::FUNC_APPLY, 32'd7, 31'd5, 31'd9, 0, 0, 0, -64'sd1, -64'sd3,
                    0, 0);
        send_fields(assm_pkg::FUNC_APPLY, 32'd0, 31'd998244352, 31'd998244353, 0, 0, 0,
                    64'd998244353, 64'd0, 0, 0);
        // compose
        send_fields(assm_pkg::FUNC_COMPOSE, 0, 0, 0, 0, 0, 0, 64'd2, 64'd3, 31'd4, 31'd5);
        send_fields(assm_pkg::FUNC_COMPOSE, 0, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0000,
                    64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_fields(assm_pkg::FUNC_COMPOSE, 0, 0, 0, 0, 0, 0, 64'd0, 64'd0, 31'd998244353,
                    31'd0);
        // merge incl. saturation
        send_fields(assm_pkg::FUNC_MERGE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'd1, 32'd1,
                    31'h7FFF_FFFF, 31'd998244352, 0, 0, 0, 0);
        send_fields(assm_pkg::FUNC_MERGE, 32'h8000_0000, 31'd3, 31'd4, 32'h7FFF_FFFF,
                    31'd5, 31'd6, 0, 0, 0, 0);
        send_fields(assm_pkg::FUNC_MERGE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // unused selector, everything set
        send_word(2'd3, {6'd0, {378{1'b1}}});
        send_random(10);

        // block fills up behind a long output hold-off
        hold_long = 1'b1;
        send_random(60);

        drain_and_load(31'd2);
        send_random(150);
        drain_and_load(31'd1);
        send_random(40);
        drain_and_load(31'd0);
        send_random(40);
        drain_and_load(31'h7FFF_FFFF);
        send_random(300);
        drain_and_load(31'd3);
        send_random(100);
        drain_and_load(31'(1000000007));
        send_random(300);
        drain_and_load(31'd65536);
        send_random(250);

        s_tvalid <= 1'b0;
        done_sending = 1'b1;
        while (sb.expected_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (PIPE_LAT + 10) @(negedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
